// ----- src/sfm_pkg.sv -----
// ----------------------------------------------------------------------------
// sfm_pkg
// Types and constants shared by the substring first-match search block.
// ----------------------------------------------------------------------------
package sfm_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned MODE_W  = 2;
   localparam int unsigned INDEX_W = 8;

   typedef enum logic [MODE_W-1:0] {
      MODE_CLEAR  = 2'd0,
      MODE_APPEND = 2'd1,
      MODE_TEXT   = 2'd2,
      MODE_END    = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type          mode;
      logic [BYTE_W-1:0] byte_value;
   } item_type;

   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] match_index;
      logic               pattern_overflow;
      logic               text_overflow;
   } result_type;

endpackage

// ----- src/sfm_in_stage.sv -----
// ----------------------------------------------------------------------------
// sfm_in_stage
// Input register. Holds one accepted item until the matcher consumes it.
// ----------------------------------------------------------------------------
module sfm_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sfm_pkg::item_type req_item,
   input  logic              consume,
   output logic              item_valid,
   output sfm_pkg::item_type item
);

   logic              valid_ff;
   logic              valid_in;
   sfm_pkg::item_type item_ff;
   logic              load;

   assign req_ready = !valid_ff || consume;
   assign load      = req_valid && req_ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (consume) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ----- src/sfm_matcher.sv -----
// ----------------------------------------------------------------------------
// sfm_matcher
// Pattern and text window registers with a parallel window compare. Each
// consumed item updates the search state; an end-of-text item also produces
// the result.
// ----------------------------------------------------------------------------
module sfm_matcher #(
   parameter int unsigned PATTERN_MAX = 16,
   parameter int unsigned TEXT_MAX    = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                consume,
   input  sfm_pkg::item_type   item,
   output logic                result_valid,
   output sfm_pkg::result_type result
);

   localparam int unsigned LW  = $clog2(PATTERN_MAX + 1);
   localparam int unsigned PW  = $clog2(TEXT_MAX + 1);
   localparam int unsigned DW0 = (PW > LW) ? PW : LW;
   localparam int unsigned DW  = (DW0 > sfm_pkg::INDEX_W) ? DW0 : sfm_pkg::INDEX_W;

   // The pattern is held newest byte first, so entry j lines up with window tap j.
   logic [sfm_pkg::BYTE_W-1:0]  pat_ff [PATTERN_MAX];
   logic [sfm_pkg::BYTE_W-1:0]  win_ff [PATTERN_MAX];
   logic [sfm_pkg::BYTE_W-1:0]  win_new [PATTERN_MAX];
   logic [LW-1:0]               len_ff;
   logic [LW-1:0]               len_in;
   logic [PW-1:0]               pos_ff;
   logic [PW-1:0]               pos_in;
   logic [PW-1:0]               pos_new;
   logic                        seen_ff;
   logic                        seen_in;
   logic [sfm_pkg::INDEX_W-1:0] first_ff;
   logic [sfm_pkg::INDEX_W-1:0] first_in;
   logic                        pov_ff;
   logic                        pov_in;
   logic                        tov_ff;
   logic                        tov_in;
   logic [PATTERN_MAX-1:0]      tap_ok;
   logic                        window_hit;
   logic [DW-1:0]               start_pos;
   logic                        pat_shift;
   logic                        win_shift;
   logic                        text_full;
   logic                        pat_full;

   assign text_full = (pos_ff == PW'(TEXT_MAX));
   assign pat_full  = (len_ff == LW'(PATTERN_MAX));
   assign pos_new   = pos_ff + PW'(1);
   assign start_pos = DW'(pos_new) - DW'(len_ff);

   always_comb begin
      win_new[0] = item.byte_value;
      for (int j = 1; j < PATTERN_MAX; j++) begin
         win_new[j] = win_ff[j-1];
      end
      for (int j = 0; j < PATTERN_MAX; j++) begin
         tap_ok[j] = (LW'(j) >= len_ff) || (win_new[j] == pat_ff[j]);
      end
      window_hit = (&tap_ok) && (len_ff != '0) && (DW'(pos_new) >= DW'(len_ff));
   end

   always_comb begin
      len_in    = len_ff;
      pos_in    = pos_ff;
      seen_in   = seen_ff;
      first_in  = first_ff;
      pov_in    = pov_ff;
      tov_in    = tov_ff;
      pat_shift = 1'b0;
      win_shift = 1'b0;
      if (consume) begin
         case (item.mode)
            sfm_pkg::MODE_CLEAR: begin
               len_in   = '0;
               pov_in   = 1'b0;
               pos_in   = '0;
               seen_in  = 1'b0;
               first_in = '0;
               tov_in   = 1'b0;
            end
            sfm_pkg::MODE_APPEND: begin
               if (pat_full) begin
                  pov_in = 1'b1;
               end else begin
                  pat_shift = 1'b1;
                  len_in    = len_ff + LW'(1);
               end
               pos_in   = '0;
               seen_in  = 1'b0;
               first_in = '0;
               tov_in   = 1'b0;
            end
            sfm_pkg::MODE_TEXT: begin
               if (text_full) begin
                  tov_in = 1'b1;
               end else begin
                  win_shift = 1'b1;
                  pos_in    = pos_new;
                  if (!seen_ff && window_hit) begin
                     seen_in  = 1'b1;
                     first_in = start_pos[sfm_pkg::INDEX_W-1:0];
                  end
               end
            end
            sfm_pkg::MODE_END: begin
               pos_in   = '0;
               seen_in  = 1'b0;
               first_in = '0;
               tov_in   = 1'b0;
            end
            default: begin
               len_in = len_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         pos_ff   <= '0;
         seen_ff  <= 1'b0;
         first_ff <= '0;
         pov_ff   <= 1'b0;
         tov_ff   <= 1'b0;
      end else begin
         len_ff   <= len_in;
         pos_ff   <= pos_in;
         seen_ff  <= seen_in;
         first_ff <= first_in;
         pov_ff   <= pov_in;
         tov_ff   <= tov_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pat_shift) begin
         pat_ff[0] <= item.byte_value;
         for (int j = 1; j < PATTERN_MAX; j++) begin
            pat_ff[j] <= pat_ff[j-1];
         end
      end
      if (win_shift) begin
         for (int j = 0; j < PATTERN_MAX; j++) begin
            win_ff[j] <= win_new[j];
         end
      end
   end

   assign result_valid            = consume && (item.mode == sfm_pkg::MODE_END);
   assign result.found            = (len_ff == '0) || seen_ff;
   assign result.match_index      = seen_ff ? first_ff : '0;
   assign result.pattern_overflow = pov_ff;
   assign result.text_overflow    = tov_ff;

endmodule

// ----- src/sfm_out_stage.sv -----
// ----------------------------------------------------------------------------
// sfm_out_stage
// Result register. Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module sfm_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  sfm_pkg::result_type result,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output sfm_pkg::result_type rsp_result
);

   logic                valid_ff;
   logic                valid_in;
   sfm_pkg::result_type result_ff;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

// ----- src/substring_first_match.sv -----
// ----------------------------------------------------------------------------
// substring_first_match
// Finds the first position of a loaded byte pattern in a streamed byte text.
//
//   Channel  Direction  Ports                       Carries
//   req      in         req_valid/ready, mode,byte  pattern or text commands
//   rsp      out        rsp_valid/ready, 4 fields   one result per end of text
//
// One item is accepted every cycle unless an end-of-text item is held by a
// stalled result; the window compare and state update sit between the input register and the result register.
// A result is loaded into the result register as its end-of-text item is consumed.
// Reset clears the pattern length, text position and flags; no sweep is needed.
// An end-of-text item waits in the input register while a result is stalled,
// and the input stalls behind it; items of the other modes never wait on the
// result side.
// ----------------------------------------------------------------------------
module substring_first_match #(
   parameter int unsigned PATTERN_MAX = 16,
   parameter int unsigned TEXT_MAX    = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_byte_value,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_found,
   output logic [7:0] rsp_match_index,
   output logic       rsp_pattern_overflow,
   output logic       rsp_text_overflow
);

   sfm_pkg::item_type   req_item;
   sfm_pkg::item_type   item;
   sfm_pkg::result_type result;
   sfm_pkg::result_type rsp_result;
   logic                item_valid;
   logic                consume;
   logic                result_valid;

   assign req_item.mode       = sfm_pkg::mode_type'(req_mode);
   assign req_item.byte_value = req_byte_value;

   assign consume = item_valid &&
                    ((item.mode != sfm_pkg::MODE_END) || !rsp_valid || rsp_ready);

   sfm_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .consume    (consume),
      .item_valid (item_valid),
      .item       (item)
   );

   sfm_matcher #(
      .PATTERN_MAX (PATTERN_MAX),
      .TEXT_MAX    (TEXT_MAX)
   ) u_matcher (
      .clock        (clock),
      .reset        (reset),
      .consume      (consume),
      .item         (item),
      .result_valid (result_valid),
      .result       (result)
   );

   sfm_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (result_valid),
      .result     (result),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result)
   );

   assign rsp_found            = rsp_result.found;
   assign rsp_match_index      = rsp_result.match_index;
   assign rsp_pattern_overflow = rsp_result.pattern_overflow;
   assign rsp_text_overflow    = rsp_result.text_overflow;

   a_end_held: assert property (@(posedge clock) disable iff (reset)
      (item_valid && item.mode == sfm_pkg::MODE_END && rsp_valid && !rsp_ready)
      |=> item_valid)
      else $error("End-of-text item dropped while the result was stalled.");

   a_result_from_end: assert property (@(posedge clock) disable iff (reset)
      result_valid |-> (item_valid && item.mode == sfm_pkg::MODE_END))
      else $error("Result produced by an item that is not end of text.");

   a_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_found || rsp_match_index == '0))
      else $error("Nonzero match index on a not-found result.");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !item_valid |-> req_ready)
      else $error("Input not ready with an empty input register.");

endmodule

// ----- dv/tb_substring_first_match.sv -----
// ----------------------------------------------------------------------------
// tb_substring_first_match
// Self-checking bench for the first-match substring search block. A table of
// corner cases runs first: empty pattern and text, pattern longer than text,
// restart of the text on a pattern write, both overflow flags and a match at
// the very end of a full text. Random pattern loads and texts follow, some
// with the pattern planted, mixed with noise and with random stalls on both
// channels. Results are checked by field against the table or a local model.
// ----------------------------------------------------------------------------
module tb_substring_first_match;

   localparam int unsigned PAT_CAP     = 16;
   localparam int unsigned TEXT_CAP    = 256;
   localparam int unsigned ITEM_GOAL   = 500;
   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned HOLD_CYCLES = 80;

   typedef struct packed {
      sfm_pkg::mode_type   mode;
      logic [7:0]          value;
      logic [9:0]          reps;
      logic                typed;
      sfm_pkg::result_type want;
   } vector_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_mode = sfm_pkg::MODE_CLEAR;
   logic [7:0] req_byte_value = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_found;
   logic [7:0] rsp_match_index;
   logic       rsp_pattern_overflow;
   logic       rsp_text_overflow;

   logic [7:0]  pat_bytes [PAT_CAP];
   int unsigned pat_len;
   logic        pat_dropped;
   logic [7:0]  text_win [PAT_CAP];
   int unsigned text_pos;
   logic        hit_seen;
   int unsigned hit_at;
   logic        text_dropped;

   sfm_pkg::result_type expected_results [$];
   int unsigned items_sent = 0;
   int unsigned results_seen = 0;
   int unsigned found_seen = 0;
   int unsigned pat_ovf_seen = 0;
   int unsigned text_ovf_seen = 0;
   int unsigned error_count = 0;
   int unsigned idle_odds = 4;
   int unsigned hold_asks = 0;
   bit          calm = 1'b0;

   // Each repeated row counts its byte up by one per transfer.
   vector_row_type dir_rows [21] = '{
      '{sfm_pkg::MODE_END,    8'hFF, 10'd1,   1'b1, '{1'b1, 8'd0,   1'b0, 1'b0}},
      '{sfm_pkg::MODE_TEXT,   8'hFF, 10'd1,   1'b0, '0},
      '{sfm_pkg::MODE_END,    8'h00, 10'd1,   1'b1, '{1'b1, 8'd0,   1'b0, 1'b0}},
      '{sfm_pkg::MODE_APPEND, 8'hFF, 10'd1,   1'b0, '0},
      '{sfm_pkg::MODE_END,    8'h00, 10'd1,   1'b1, '{1'b0, 8'd0,   1'b0, 1'b0}},
      '{sfm_pkg::MODE_TEXT,   8'h00, 10'd1,   1'b0, '0},
      '{sfm_pkg::MODE_TEXT,   8'hFF, 10'd1,   1'b0, '0},
      '{sfm_pkg::MODE_END,    8'h00, 10'd1,   1'b1, '{1'b1, 8'd1,   1'b0, 1'b0}},
      '{sfm_pkg::MODE_APPEND, 8'h00, 10'd1,   1'b0, '0},
      '{sfm_pkg::MODE_TEXT,   8'hFF, 10'd1,   1'b0, '0},
      '{sfm_pkg::MODE_END,    8'h00, 10'd1,   1'b1, '{1'b0, 8'd0,   1'b0, 1'b0}},
      '{sfm_pkg::MODE_TEXT,   8'hFF, 10'd1,   1'b0, '0},
      '{sfm_pkg::MODE_TEXT,   8'h00, 10'd1,   1'b0, '0},
      '{sfm_pkg::MODE_APPEND, 8'h55, 10'd1,   1'b0, '0},
      '{sfm_pkg::MODE_TEXT,   8'h55, 10'd1,   1'b0, '0},
      '{sfm_pkg::MODE_END,    8'h00, 10'd1,   1'b1, '{1'b0, 8'd0,   1'b0, 1'b0}},
      '{sfm_pkg::MODE_CLEAR,  8'hFF, 10'd1,   1'b0, '0},
      '{sfm_pkg::MODE_APPEND, 8'hF0, 10'd17,  1'b0, '0},
      '{sfm_pkg::MODE_TEXT,   8'h00, 10'd257, 1'b0, '0},
      '{sfm_pkg::MODE_END,    8'h00, 10'd1,   1'b1, '{1'b1, 8'd240, 1'b1, 1'b1}},
      '{sfm_pkg::MODE_END,    8'h00, 10'd1,   1'b1, '{1'b0, 8'd0,   1'b1, 1'b0}}
   };

   substring_first_match u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_mode             (req_mode),
      .req_byte_value       (req_byte_value),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_found            (rsp_found),
      .rsp_match_index      (rsp_match_index),
      .rsp_pattern_overflow (rsp_pattern_overflow),
      .rsp_text_overflow    (rsp_text_overflow)
   );

   initial begin
      forever begin
         #4 clock = ~clock;
      end
   end

   function automatic void restart_text();
      foreach (text_win[i]) text_win[i] = 8'h00;
      text_pos     = 0;
      hit_seen     = 1'b0;
      hit_at       = 0;
      text_dropped = 1'b0;
   endfunction

   function automatic bit advance_search(input sfm_pkg::mode_type m, input logic [7:0] b,
                                         output sfm_pkg::result_type r);
      bit made = 1'b0;
      bit hit;
      r = '0;
      case (m)
         sfm_pkg::MODE_CLEAR: begin
            pat_len     = 0;
            pat_dropped = 1'b0;
            restart_text();
         end
         sfm_pkg::MODE_APPEND: begin
            if (pat_len < PAT_CAP) begin
               pat_bytes[pat_len] = b;
               pat_len++;
            end else begin
               pat_dropped = 1'b1;
            end
            restart_text();
         end
         sfm_pkg::MODE_TEXT: begin
            if (text_pos >= TEXT_CAP) begin
               text_dropped = 1'b1;
            end else begin
               for (int i = PAT_CAP - 1; i > 0; i--) text_win[i] = text_win[i-1];
               text_win[0] = b;
               text_pos++;
               if (!hit_seen && pat_len != 0 && text_pos >= pat_len) begin
                  hit = 1'b1;
                  for (int k = 0; k < pat_len; k++) begin
                     if (text_win[pat_len-1-k] != pat_bytes[k]) hit = 1'b0;
                  end
                  if (hit) begin
                     hit_seen = 1'b1;
                     hit_at   = text_pos - pat_len;
                  end
               end
            end
         end
         sfm_pkg::MODE_END: begin
            r.found            = (pat_len == 0) || hit_seen;
            r.match_index      = (pat_len != 0 && hit_seen) ? 8'(hit_at) : 8'd0;
            r.pattern_overflow = pat_dropped;
            r.text_overflow    = text_dropped;
            restart_text();
            made = 1'b1;
         end
         default: begin
            made = 1'b0;
         end
      endcase
      return made;
   endfunction

   function automatic logic [7:0] pick_byte(input logic [7:0] alpha);
      if ($urandom_range(0, 7) == 0) return 8'($urandom);
      return alpha + 8'($urandom_range(0, 2));
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= 30) begin
         $display("mismatch on result %0d: %s got %0h, expected %0h",
                  results_seen, what, got, want);
      end
   endtask

   task automatic pause_sender(input int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   task automatic send_item(input sfm_pkg::mode_type m, input logic [7:0] b,
                            input logic typed = 1'b0,
                            input sfm_pkg::result_type want = '0);
      sfm_pkg::result_type r;
      if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         pause_sender($urandom_range(1, 13));
      end
      req_valid      <= 1'b1;
      req_mode       <= m;
      req_byte_value <= b;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (advance_search(m, b, r)) expected_results.push_back(typed ? want : r);
   endtask

   initial begin : result_side
      int unsigned         stall_left = 0;
      int unsigned         hold_seen = 0;
      bit                  quiet = 1'b0;
      sfm_pkg::result_type got;
      sfm_pkg::result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got = {rsp_found, rsp_match_index, rsp_pattern_overflow, rsp_text_overflow};
            results_seen++;
            if (got.found) found_seen++;
            if (got.pattern_overflow) pat_ovf_seen++;
            if (got.text_overflow) text_ovf_seen++;
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing expected", 32'(got), 0);
            end else begin
               want = expected_results.pop_front();
               if (got.found !== want.found)
                  report_mismatch("found", 32'(got.found), 32'(want.found));
               if (got.match_index !== want.match_index)
                  report_mismatch("match_index", 32'(got.match_index),
                                  32'(want.match_index));
               if (got.pattern_overflow !== want.pattern_overflow)
                  report_mismatch("pattern_overflow", 32'(got.pattern_overflow),
                                  32'(want.pattern_overflow));
               if (got.text_overflow !== want.text_overflow)
                  report_mismatch("text_overflow", 32'(got.text_overflow),
                                  32'(want.text_overflow));
            end
         end
         if ($urandom_range(0, 99) == 0) quiet = !quiet;
         if (hold_seen != hold_asks) begin
            hold_seen  = hold_asks;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && !calm && !quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 13);
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int unsigned idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("tb_substring_first_match: done, errors");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int unsigned seq_no = 0;
      int unsigned plen;
      int unsigned tlen;
      int unsigned at;
      logic [7:0]  alpha = 8'h41;
      logic [7:0]  text_q [$];

      pat_len     = 0;
      pat_dropped = 1'b0;
      restart_text();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         for (int j = 0; j < int'(dir_rows[i].reps); j++) begin
            send_item(dir_rows[i].mode, dir_rows[i].value + 8'(j),
                      dir_rows[i].typed, dir_rows[i].want);
         end
      end

      while (items_sent < ITEM_GOAL) begin
         seq_no++;
         calm = (items_sent >= ITEM_GOAL - ITEM_GOAL / 5);
         case ($urandom_range(0, 2))
            0: idle_odds = 0;
            1: idle_odds = 3;
            default: idle_odds = 12;
         endcase
         if (seq_no == 6) begin
            // The receiver holds off while end-of-text transfers keep coming.
            idle_odds = 0;
            hold_asks++;
            repeat (8) send_item(sfm_pkg::MODE_END, 8'($urandom));
         end else if (seq_no % 12 == 0) begin
            wait_drained();
         end
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4)) begin
               send_item(sfm_pkg::mode_type'($urandom_range(0, 3)), 8'($urandom));
            end
         end else begin
            if (seq_no == 1 || $urandom_range(0, 3) == 0) begin
               alpha = 8'($urandom);
               send_item(sfm_pkg::MODE_CLEAR, 8'($urandom));
               plen = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 18)
                                                  : $urandom_range(0, 5);
               repeat (plen) send_item(sfm_pkg::MODE_APPEND, pick_byte(alpha));
            end
            tlen = ($urandom_range(0, 59) == 0) ? $urandom_range(250, 270)
                                                : $urandom_range(0, 14);
            text_q.delete();
            repeat (tlen) text_q.push_back(pick_byte(alpha));
            if (pat_len != 0 && pat_len <= tlen && $urandom_range(0, 2) == 0) begin
               at = $urandom_range(0, tlen - pat_len);
               for (int k = 0; k < pat_len; k++) text_q[at+k] = pat_bytes[k];
            end
            foreach (text_q[i]) begin
               if ($urandom_range(0, 49) == 0) begin
                  send_item(sfm_pkg::MODE_APPEND, pick_byte(alpha));
               end
               send_item(sfm_pkg::MODE_TEXT, text_q[i]);
            end
            send_item(sfm_pkg::MODE_END, 8'($urandom));
         end
      end

      calm = 1'b1;
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (expected_results.size() != 0) begin
         report_mismatch("results still outstanding", expected_results.size(), 0);
      end

      $display("run covered %0d transfers in, %0d results out, %0d with a match",
               items_sent, results_seen, found_seen);
      $display("pattern overflow reported %0d times, text overflow %0d times",
               pat_ovf_seen, text_ovf_seen);
      if (error_count == 0) begin
         $display("tb_substring_first_match: done, clean");
      end else begin
         $display("tb_substring_first_match: done, errors");
      end
      $finish;
   end

endmodule
